FILE: hw/rtl/updown_compressor_band_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the up/down compressor band core
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UPDOWN_COMPRESSOR_BAND_CORE_MACROS_SVH
`define UPDOWN_COMPRESSOR_BAND_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define UCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define UCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCB_ASSERT_NOW(lbl, ante, cons, msg)
`define UCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ucb_pkg.sv
// ---------------------------------------------------------------------------
// ucb_pkg
// Shared types, constants and the 2^(2^-k) root table for the band core.
// ---------------------------------------------------------------------------
package ucb_pkg;

    // Channel configuration
    localparam int CHANNELS = 2;
    localparam int ACTIVE   = (CHANNELS < 2) ? CHANNELS : 2;

    // Register indexes
    localparam logic [2:0] CFG_ATTACK  = 3'd0;
    localparam logic [2:0] CFG_RELEASE = 3'd1;
    localparam logic [2:0] CFG_LINK    = 3'd2;
    localparam logic [2:0] CFG_DRIVE   = 3'd3;
    localparam logic [2:0] CFG_BALANCE = 3'd4;
    localparam logic [2:0] CFG_TRIM    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_ATTACK  = 16'd64685;
    localparam logic [15:0] RST_RELEASE = 16'd65530;
    localparam logic [16:0] RST_LINK    = 17'd55706;
    localparam logic [15:0] RST_DRIVE   = 16'd15565;
    localparam logic [16:0] RST_BALANCE = 17'd32768;
    localparam logic [12:0] RST_TRIM    = 13'd0;

    typedef struct packed {
        logic [15:0] att_coeff;
        logic [15:0] rel_coeff;
        logic [16:0] link_amt;
        logic [15:0] drive;
        logic [16:0] balance;
        logic [12:0] trim;
    } t_cfg;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_BTERM, OP_TDN, OP_TUP, OP_SDN, OP_SUP,
        OP_SQ, OP_F1, OP_F2, OP_SQI, OP_SQS, OP_STA, OP_BL1, OP_BL2,
        OP_LGI, OP_LGN, OP_LGM, OP_LGS, OP_LEV, OP_DIV, OP_GAIN, OP_TOT,
        OP_AM, OP_EXP, OP_OUT1, OP_OUT2, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;   // 0: linked envelope, 1..ACTIVE: channel sel-1
        logic [4:0] cnt;   // iteration index
    } t_cmd;

    typedef struct packed {
        logic norm_top;
        logic out_full;
        logic out_take;
    } t_stat;

    typedef logic [30:0] t_root_arr [16];

    // Floor square root, evaluated at elaboration only
    function automatic logic [31:0] isqrt_c(input logic [63:0] v);
        logic [35:0] rem;
        logic [35:0] trial;
        logic [31:0] root;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = {rem[33:0], v[2*i +: 2]};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[30:0], 1'b1};
            end else begin
                root = {root[30:0], 1'b0};
            end
        end
        return root;
    endfunction

    // Entry j holds the Q1.30 root 2^(2^-(16-j)) by repeated square roots
    function automatic t_root_arr build_roots();
        t_root_arr   t;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            r = {32'd0, isqrt_c(r << 30)};
            t[16-k] = r[30:0];
        end
        return t;
    endfunction

    localparam t_root_arr ROOT_TBL = build_roots();

endpackage

FILE: hw/rtl/ucb_ctrl.sv
// ---------------------------------------------------------------------------
// ucb_ctrl
// Sequencer: steps the datapath through one frame and hands off the result.
// ---------------------------------------------------------------------------
`include "updown_compressor_band_core_macros.svh"
module ucb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ucb_pkg::t_stat i_stat,
    output ucb_pkg::t_cmd  o_cmd
);
    import ucb_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE = 23'd1 << 0,  S_PRE  = 23'd1 << 1,  S_SQ   = 23'd1 << 2,
        S_F1   = 23'd1 << 3,  S_F2   = 23'd1 << 4,  S_SQI  = 23'd1 << 5,
        S_SQS  = 23'd1 << 6,  S_STA  = 23'd1 << 7,  S_BL1  = 23'd1 << 8,
        S_BL2  = 23'd1 << 9,  S_LGI  = 23'd1 << 10, S_LGN  = 23'd1 << 11,
        S_LGM  = 23'd1 << 12, S_LGS  = 23'd1 << 13, S_LEV  = 23'd1 << 14,
        S_DIV  = 23'd1 << 15, S_GAIN = 23'd1 << 16, S_TOT  = 23'd1 << 17,
        S_AM   = 23'd1 << 18, S_EXP  = 23'd1 << 19, S_OUT1 = 23'd1 << 20,
        S_OUT2 = 23'd1 << 21, S_EMIT = 23'd1 << 22
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic [4:0] r_cnt, n_cnt;
    t_op        w_op;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = '{op: w_op, sel: r_sel, cnt: r_cnt};

    // Next state and command
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        w_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = S_PRE;
                    n_cnt   = 5'd0;
                end
            end
            S_PRE: begin
                case (r_cnt[2:0])
                    3'd0:    w_op = OP_BTERM;
                    3'd1:    w_op = OP_TDN;
                    3'd2:    w_op = OP_TUP;
                    3'd3:    w_op = OP_SDN;
                    default: w_op = OP_SUP;
                endcase
                if (r_cnt == 5'd4) begin
                    n_state = S_SQ;
                    n_sel   = 2'd0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQ: begin
                w_op    = OP_SQ;
                n_state = S_F1;
            end
            S_F1: begin
                w_op    = OP_F1;
                n_state = S_F2;
            end
            S_F2: begin
                w_op    = OP_F2;
                n_state = S_SQI;
            end
            S_SQI: begin
                w_op    = OP_SQI;
                n_state = S_SQS;
                n_cnt   = 5'd31;
            end
            S_SQS: begin
                w_op  = OP_SQS;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) n_state = S_STA;
            end
            S_STA: begin
                w_op = OP_STA;
                if (r_sel == 2'd0) begin
                    n_sel   = 2'd1;
                    n_state = S_SQ;
                end else begin
                    n_state = S_BL1;
                end
            end
            S_BL1: begin
                w_op    = OP_BL1;
                n_state = S_BL2;
            end
            S_BL2: begin
                w_op    = OP_BL2;
                n_state = S_LGI;
            end
            S_LGI: begin
                w_op    = OP_LGI;
                n_state = S_LGN;
            end
            S_LGN: begin
                w_op = OP_LGN;
                if (i_stat.norm_top) n_state = S_LGM;
            end
            S_LGM: begin
                w_op    = OP_LGM;
                n_state = S_LGS;
                n_cnt   = 5'd15;
            end
            S_LGS: begin
                w_op  = OP_LGS;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) n_state = S_LEV;
            end
            S_LEV: begin
                w_op    = OP_LEV;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_op    = OP_DIV;
                n_state = S_GAIN;
            end
            S_GAIN: begin
                w_op    = OP_GAIN;
                n_state = S_TOT;
            end
            S_TOT: begin
                w_op    = OP_TOT;
                n_state = S_AM;
            end
            S_AM: begin
                w_op    = OP_AM;
                n_state = S_EXP;
                n_cnt   = 5'd15;
            end
            S_EXP: begin
                w_op  = OP_EXP;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) n_state = S_OUT1;
            end
            S_OUT1: begin
                w_op    = OP_OUT1;
                n_state = S_OUT2;
            end
            S_OUT2: begin
                w_op = OP_OUT2;
                if (r_sel == 2'(ACTIVE)) begin
                    n_state = S_EMIT;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_full || i_stat.out_take) begin
                    w_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 2'd0;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
        end
    end

    `UCB_ASSERT_NEXT(a_accept_starts, r_state == S_IDLE && i_in_valid, r_state == S_PRE && r_cnt == 5'd0, "accepted frame did not start the sequence")
    `UCB_ASSERT_NEXT(a_sqrt_len, r_state == S_SQS && r_cnt == 5'd0, r_state == S_STA, "square root did not finish after its last step")
    `UCB_ASSERT_NOW(a_emit_free, w_op == OP_EMIT, !i_stat.out_full || i_stat.out_take, "result overwrote an untaken transfer")

endmodule

FILE: hw/rtl/ucb_dp.sv
// ---------------------------------------------------------------------------
// ucb_dp
// Datapath: envelopes, square root, log, gain law, exp and output register.
// ---------------------------------------------------------------------------
module ucb_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ucb_pkg::t_cfg  i_cfg,
    input  ucb_pkg::t_cmd  i_cmd,
    output ucb_pkg::t_stat o_stat,
    input  logic [47:0]    i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [79:0]    o_out_data
);
    import ucb_pkg::*;

    localparam logic [23:0] FIX_24  = 24'd1572864;   // 24 dB in Q.16
    localparam logic [25:0] FIX_120 = 26'd7864320;   // 120 dB
    localparam logic [21:0] FIX_31  = 22'd2031616;   // 31 in Q.16

    // Frame and envelope state
    logic [23:0] r_smp [2];
    logic [23:0] r_mag [2];
    logic [23:0] r_lmag;
    logic [31:0] r_env [2];
    logic [31:0] r_envl;
    // Per-frame scales
    logic [15:0] r_bterm;
    logic [17:0] r_td;
    logic [18:0] r_tu;
    logic [17:0] r_ds;
    logic [18:0] r_us;
    // Working registers
    logic [31:0] r_p;
    logic [15:0] r_c;
    logic [55:0] r_prod;
    logic [63:0] r_rad;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_alink;
    logic [31:0] r_aown;
    logic [32:0] r_used;
    logic [32:0] r_norm;
    logic [5:0]  r_e;
    logic [30:0] r_m;
    logic [15:0] r_frac;
    logic        r_levneg;
    logic [23:0] r_levm;
    logic [23:0] r_d;
    logic        r_dn, r_up;
    logic [23:0] r_gdm;
    logic [20:0] r_gup;
    logic [22:0] r_tot;
    logic [20:0] r_b;
    logic [23:0] r_y [2];
    logic [20:0] r_upm;
    logic [23:0] r_dnm;
    logic        r_o_valid;
    logic [79:0] r_o_data;

    logic        w_ch, w_link;
    logic [23:0] w_in0, w_in1, w_abs0, w_abs1, w_sqm;
    logic [47:0] w_sq;
    logic [31:0] w_env;
    logic [15:0] w_c;
    logic [48:0] w_fsum;
    logic [35:0] w_srem, w_strial;
    logic [16:0] w_l, w_bal;
    logic [32:0] w_bt;
    logic [33:0] w_tdp;
    logic [34:0] w_tup;
    logic [35:0] w_sdp;
    logic [36:0] w_sup;
    logic [55:0] w_bsum;
    logic [61:0] w_msq;
    logic [31:0] w_t;
    logic [21:0] w_lraw, w_labs;
    logic        w_lneg;
    logic [41:0] w_lp;
    logic [25:0] w_lm;
    logic        w_dn, w_up;
    logic [23:0] w_over, w_under;
    logic [26:0] w_xdn;
    logic [27:0] w_xup;
    logic [56:0] w_q12p;
    logic [57:0] w_q20p;
    logic [18:0] w_sc;
    logic [42:0] w_gp;
    logic [26:0] w_g;
    logic signed [25:0] w_tsum;
    logic [21:0] w_tabs;
    logic [43:0] w_ap;
    logic [19:0] w_am;
    logic [62:0] w_ep;
    logic [5:0]  w_sh;
    logic [55:0] w_rnd, w_ym;
    logic [23:0] w_ysat;
    logic [15:0] w_dn8;

    assign w_ch   = 1'(i_cmd.sel - 2'd1);
    assign w_link = (i_cmd.sel == 2'd0);

    // Sample magnitudes
    assign w_in0  = i_in_data[23:0];
    assign w_in1  = i_in_data[47:24];
    assign w_abs0 = w_in0[23] ? 24'(~w_in0 + 24'd1) : w_in0;
    assign w_abs1 = w_in1[23] ? 24'(~w_in1 + 24'd1) : w_in1;

    // Power and envelope step
    assign w_sqm  = w_link ? r_lmag : r_mag[w_ch];
    assign w_sq   = 48'(w_sqm) * 48'(w_sqm);
    assign w_env  = w_link ? r_envl : r_env[w_ch];
    assign w_c    = (r_p > w_env) ? i_cfg.att_coeff : i_cfg.rel_coeff;
    assign w_fsum = 49'(r_prod[47:0])
                  + 49'(17'h10000 - {1'b0, r_c}) * 49'(r_p) + 49'd32768;

    // Square root digit step
    assign w_srem   = {r_rem[33:0], r_rad[63:62]};
    assign w_strial = {2'b00, r_root, 2'b01};

    // Clamped blend controls and per-frame scales
    assign w_l   = (i_cfg.link_amt > 17'h10000) ? 17'h10000 : i_cfg.link_amt;
    assign w_bal = (i_cfg.balance > 17'h10000) ? 17'h10000 : i_cfg.balance;
    assign w_bt  = 33'(w_bal) * 33'd45875 + 33'd32768;
    assign w_tdp = 34'(i_cfg.drive) * 34'd60293 + 34'd8192;
    assign w_tup = 35'(i_cfg.drive) * 35'd77332 + 35'd8192;
    assign w_sdp = 36'(r_td) * 36'(17'd95027 - {1'b0, r_bterm}) + 36'd32768;
    assign w_sup = 37'(r_tu) * 37'(17'd49152 + {1'b0, r_bterm}) + 37'd32768;

    // Blend of own and linked amplitude
    assign w_bsum = r_prod + 56'(r_alink) * 56'(w_l) + 56'd32768;

    // Log2 fraction step
    assign w_msq = 62'(r_m) * 62'(r_m);
    assign w_t   = w_msq[61:30];

    // Level in dB
    assign w_lraw = {r_e, r_frac};
    assign w_lneg = (w_lraw < FIX_31);
    assign w_labs = w_lneg ? (FIX_31 - w_lraw) : (w_lraw - FIX_31);
    assign w_lp   = 42'(w_labs) * 42'd394566 + 42'd32768;
    assign w_lm   = w_lp[41:16];

    // Over and under threshold, divided by 12 and by 20
    assign w_dn    = !r_levneg || (r_levm < FIX_24);
    assign w_up    = r_levneg && (r_levm > FIX_24);
    assign w_over  = r_levneg ? (FIX_24 - r_levm) : (FIX_24 + r_levm);
    assign w_under = r_levm - FIX_24;
    assign w_xdn   = 27'(w_over) * 27'd11 + 27'd6;
    assign w_xup   = 28'(w_under) * 28'd13 + 28'd10;
    assign w_q12p  = 57'(w_xdn[26:2]) * 57'(32'hAAAAAAAB);
    assign w_q20p  = 58'(w_xup[27:2]) * 58'(32'hCCCCCCCD);

    // Gain law
    assign w_sc = r_dn ? 19'(r_ds) : r_us;
    assign w_gp = 43'(r_d) * 43'(w_sc) + 43'd32768;
    assign w_g  = w_gp[42:16];

    // Total gain, exponent split
    assign w_tsum = $signed({5'd0, r_gup}) - $signed({2'd0, r_gdm})
                  + $signed({{5{i_cfg.trim[12]}}, i_cfg.trim, 8'd0});
    assign w_tabs = r_tot[22] ? 22'(~r_tot + 23'd1) : 22'(r_tot);
    assign w_ap   = 44'(w_tabs) * 44'd2786635 + 44'd8388608;
    assign w_am   = w_ap[43:24];
    assign w_ep   = 63'(r_m) * 63'(ROOT_TBL[i_cmd.cnt[3:0]]) + 63'd536870912;

    // Scale, round and saturate the sample
    assign w_sh  = 6'd46 - {1'b0, r_b[20:16]};
    assign w_rnd = r_prod + (56'd1 << (w_sh - 6'd1));
    assign w_ym  = w_rnd >> w_sh;
    always_comb begin
        if (r_smp[w_ch][23]) begin
            w_ysat = (w_ym > 56'h800000) ? 24'h800000 : 24'(~w_ym[23:0] + 24'd1);
            if (w_ym > 56'h800000) w_ysat = 24'h800000;
        end else begin
            w_ysat = (w_ym > 56'h7FFFFF) ? 24'h7FFFFF : w_ym[23:0];
        end
    end

    assign w_dn8 = 16'(~(16'((r_dnm + 24'd128) >> 8)) + 16'd1);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_smp[0] <= w_in0;
                r_smp[1] <= w_in1;
                r_mag[0] <= w_abs0;
                r_mag[1] <= w_abs1;
                r_lmag   <= (ACTIVE > 1 && w_abs1 > w_abs0) ? w_abs1 : w_abs0;
                r_y[0]   <= '0;
                r_y[1]   <= '0;
                r_upm    <= '0;
                r_dnm    <= '0;
            end
            OP_BTERM: r_bterm <= w_bt[31:16];
            OP_TDN:   r_td    <= 18'(w_tdp >> 14);
            OP_TUP:   r_tu    <= 19'(w_tup >> 14);
            OP_SDN:   r_ds    <= (w_sdp[35:16] > 20'd222822) ? 18'd222822 : 18'(w_sdp[35:16]);
            OP_SUP:   r_us    <= (w_sup[36:16] > 21'd275251) ? 19'd275251 : 19'(w_sup[36:16]);
            OP_SQ:    r_p     <= w_sq[46:15];
            OP_F1: begin
                r_c    <= w_c;
                r_prod <= 56'(w_c) * 56'(w_env);
            end
            OP_SQI: begin
                r_rad  <= {1'b0, w_env, 31'd0};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQS: begin
                r_rad <= {r_rad[61:0], 2'b00};
                if (w_srem >= w_strial) begin
                    r_rem  <= w_srem - w_strial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_srem;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_STA: begin
                if (w_link) r_alink <= r_root;
                else        r_aown  <= r_root;
            end
            OP_BL1: r_prod <= 56'(r_aown) * 56'(17'h10000 - w_l);
            OP_BL2: r_used <= 33'(w_bsum >> 16) + 33'd2;
            OP_LGI: begin
                r_norm <= r_used;
                r_e    <= 6'd32;
            end
            OP_LGN: begin
                if (!r_norm[32]) begin
                    r_norm <= {r_norm[31:0], 1'b0};
                    r_e    <= r_e - 6'd1;
                end
            end
            OP_LGM: begin
                r_m    <= r_norm[32:2];
                r_frac <= '0;
            end
            OP_LGS: begin
                if (w_t[31]) begin
                    r_m                     <= w_t[31:1];
                    r_frac[i_cmd.cnt[3:0]]  <= 1'b1;
                end else begin
                    r_m <= w_t[30:0];
                end
            end
            OP_LEV: begin
                r_levneg <= w_lneg;
                r_levm   <= (w_lneg && w_lm > FIX_120) ? 24'(FIX_120) : 24'(w_lm);
            end
            OP_DIV: begin
                r_dn <= w_dn;
                r_up <= w_up;
                if (w_dn)      r_d <= w_q12p[56:33];
                else if (w_up) r_d <= w_q20p[57:34];
                else           r_d <= '0;
            end
            OP_GAIN: begin
                r_gdm <= r_dn ? 24'(w_g) : 24'd0;
                if (!r_up)                    r_gup <= '0;
                else if (w_g > 27'(FIX_24))   r_gup <= 21'(FIX_24);
                else                          r_gup <= w_g[20:0];
            end
            OP_TOT: begin
                if (w_tsum < -26'sd3145728)     r_tot <= 23'(-26'sd3145728);
                else if (w_tsum > 26'sd1966080) r_tot <= 23'd1966080;
                else                            r_tot <= 23'(w_tsum);
                if (r_gup > r_upm) r_upm <= r_gup;
                if (r_gdm > r_dnm) r_dnm <= r_gdm;
            end
            OP_AM: begin
                r_b <= r_tot[22] ? (21'h100000 - 21'(w_am)) : (21'h100000 + 21'(w_am));
                r_m <= 31'h40000000;
            end
            OP_EXP: begin
                if (r_b[i_cmd.cnt[3:0]]) r_m <= w_ep[60:30];
            end
            OP_OUT1: r_prod <= 56'(r_mag[w_ch]) * 56'(r_m);
            OP_OUT2: r_y[w_ch] <= w_ysat;
            default: ;
        endcase
        if (i_cmd.op == OP_F2) begin
            if (w_link) r_envl        <= w_fsum[47:16];
            else        r_env[w_ch]   <= w_fsum[47:16];
        end
        if (i_cmd.op == OP_EMIT) begin
            r_o_data <= {3'd0, w_dn8, 13'((r_upm + 21'd128) >> 8), r_y[1], r_y[0]};
        end
        if (!i_rst_n) begin
            r_env[0] <= '0;
            r_env[1] <= '0;
            r_envl   <= '0;
        end
    end

    // Output hold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_stat      = '{norm_top: r_norm[32], out_full: r_o_valid, out_take: i_out_ready};

endmodule

FILE: hw/rtl/updown_compressor_band_core.sv
// ---------------------------------------------------------------------------
// updown_compressor_band_core
// One band of an upward/downward compressor, one stereo frame per transfer.
// ---------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   48     sample_ch0, sample_ch1
// m_axis    out  80     out_ch0, out_ch1, up_gain_db, down_gain_db
// cfg       in   3+17   register index and write data, no read-back
//
// The time from accept to result is set by the three 32-step square roots, the
// 16-step log and exp loops of each channel and the log normalisation, which
// shifts out one leading zero of the blend per step.
// A new frame is accepted while the previous result still waits on m_axis.
// Reset is synchronous, active low; it clears the envelopes, loads the register
// set with its reset values and resets the sequencer.
// ---------------------------------------------------------------------------
module updown_compressor_band_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // sample_ch0, sample_ch1
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // out_ch0, out_ch1, up_gain_db, down_gain_db
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);
    import ucb_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{att_coeff: RST_ATTACK, rel_coeff: RST_RELEASE, link_amt: RST_LINK,
                       drive: RST_DRIVE, balance: RST_BALANCE, trim: RST_TRIM};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_cfg.att_coeff <= i_cfg_data[15:0];
                CFG_RELEASE: r_cfg.rel_coeff <= i_cfg_data[15:0];
                CFG_LINK:    r_cfg.link_amt  <= i_cfg_data;
                CFG_DRIVE:   r_cfg.drive     <= i_cfg_data[15:0];
                CFG_BALANCE: r_cfg.balance   <= i_cfg_data;
                CFG_TRIM:    r_cfg.trim      <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ucb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ucb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

FILE: bench/updown_compressor_band_checker.sv
// ----------------------------------------------------------------------------
// Up/down compressor band checker
// Watches the sample, result and register-write channels of the band core. It
// keeps its own envelope state and register copy, computes each expected output
// frame on every input transfer, and compares the output transfers in order.
// ----------------------------------------------------------------------------
module updown_compressor_band_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ucb_pkg::*;

    // Most significant field first, so out0 lands in the lowest bits
    typedef struct packed {
        logic [15:0] down_db;
        logic [12:0] up_db;
        logic [23:0] out1;
        logic [23:0] out0;
    } t_frame;

    localparam longint DB_KNEE = -(64'sd24 <<< 16);

    t_cfg          regs;
    logic [31:0]   chan_env [2];
    logic [31:0]   link_env;
    t_frame        frame_q [$];

    // Floor square root of a 64-bit value
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // log2 in Q.16 by repeated squaring of the Q1.30 mantissa
    function automatic longint log2_fix(input longint unsigned v);
        int              e = 63;
        longint unsigned m;
        longint          frac = 0;
        while (e > 0 && !v[e]) e--;
        m = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (64'sd1 <<< i);
            end
        end
        return (longint'(e) <<< 16) + frac;
    endfunction

    // 2^(f/65536) in Q1.30 from iterated roots of two
    function automatic longint unsigned pow2_frac(input longint unsigned f);
        longint unsigned m = 64'd1 << 30;
        longint unsigned r = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            r = root64(r << 30);
            if (((f >> (16 - k)) & 1) != 0) m = (m * r + (64'd1 << 29)) >> 30;
        end
        return m;
    endfunction

    // One-pole power step, attack when rising
    function automatic logic [31:0] env_step(input logic [31:0] env,
                                             input longint unsigned p);
        longint unsigned c;
        longint unsigned s;
        c = (p > env) ? longint'(regs.att_coeff) : longint'(regs.rel_coeff);
        s = (c * env + (65536 - c) * p + 32768) >> 16;
        return s[31:0];
    endfunction

    function automatic longint unsigned drive_scale(input longint unsigned bias,
                                                    input longint unsigned k,
                                                    input longint unsigned cap);
        longint unsigned t;
        longint unsigned s;
        t = (longint'(regs.drive) * k + 8192) >> 14;
        s = (t * bias + 32768) >> 16;
        return (s > cap) ? cap : s;
    endfunction

    // Advance the envelopes by one frame and return the expected output
    function automatic t_frame process_frame(input logic [47:0] d);
        longint          smp [2];
        longint unsigned mag [2];
        longint unsigned lmag = 0;
        longint unsigned lk, bal, bterm, dscale, uscale, alink;
        longint unsigned aown, used, dd, am, bb, mm, ym, sh;
        longint          trim, lv, lev, gdn, gup, tot, a, ip;
        longint          upm = 0;
        longint          dnm = 0;
        t_frame          res;
        logic [23:0]     oval [2];

        smp[0] = longint'($signed(d[23:0]));
        smp[1] = longint'($signed(d[47:24]));
        for (int ch = 0; ch < 2; ch++) begin
            mag[ch] = (smp[ch] < 0) ? -smp[ch] : smp[ch];
            if (mag[ch] > lmag) lmag = mag[ch];
        end
        lk  = (regs.link_amt > 65536) ? 65536 : regs.link_amt;
        bal = (regs.balance > 65536) ? 65536 : regs.balance;
        bterm  = (45875 * bal + 32768) >> 16;
        dscale = drive_scale(95027 - bterm, 60293, 222822);
        uscale = drive_scale(49152 + bterm, 77332, 275251);
        trim   = longint'($signed(regs.trim)) * 256;

        link_env = env_step(link_env, (lmag * lmag) >> 15);
        alink    = root64(longint'(link_env) << 31);

        for (int ch = 0; ch < 2; ch++) begin
            gdn = 0;
            gup = 0;
            chan_env[ch] = env_step(chan_env[ch], (mag[ch] * mag[ch]) >> 15);
            aown = root64(longint'(chan_env[ch]) << 31);
            used = ((aown * (65536 - lk) + alink * lk + 32768) >> 16) + 2;
            lv   = log2_fix(used) - (64'sd31 <<< 16);
            if (lv < 0) lev = -longint'((longint'(-lv) * 394566 + 32768) >> 16);
            else        lev =  longint'((longint'(lv) * 394566 + 32768) >> 16);
            if (lev < -(64'sd120 <<< 16)) lev = -(64'sd120 <<< 16);

            // Downward gain above the knee, upward gain below it
            if (lev > DB_KNEE) begin
                dd  = (longint'(lev - DB_KNEE) * 11 + 6) / 12;
                gdn = -longint'((dd * dscale + 32768) >> 16);
            end
            if (lev < DB_KNEE) begin
                dd  = (longint'(DB_KNEE - lev) * 13 + 10) / 20;
                gup = longint'((dd * uscale + 32768) >> 16);
                if (gup > (64'sd24 <<< 16)) gup = 64'sd24 <<< 16;
            end
            tot = gdn + gup + trim;
            if (tot < -(64'sd48 <<< 16)) tot = -(64'sd48 <<< 16);
            if (tot > (64'sd30 <<< 16))  tot = 64'sd30 <<< 16;

            // dB to linear and apply
            am = (longint'((tot < 0) ? -tot : tot) * 2786635 + (64'd1 << 23)) >> 24;
            a  = (tot < 0) ? -longint'(am) : longint'(am);
            bb = a + (64'sd16 <<< 16);
            ip = longint'(bb >> 16) - 16;
            mm = pow2_frac(bb & 16'hFFFF);
            sh = 30 - ip;
            ym = (mag[ch] * mm + (64'd1 << (sh - 1))) >> sh;
            if (smp[ch] < 0) begin
                if (ym > 8388608) ym = 8388608;
                oval[ch] = 24'(25'h100_0000 - ym);
            end else begin
                if (ym > 8388607) ym = 8388607;
                oval[ch] = ym[23:0];
            end
            if (gup > upm) upm = gup;
            if (gdn < dnm) dnm = gdn;
        end
        res.out0    = oval[0];
        res.out1    = oval[1];
        res.up_db   = 13'((longint'(upm) + 128) >> 8);
        res.down_db = 16'(17'h10000 - ((longint'(-dnm) + 128) >> 8));
        return res;
    endfunction

    assign o_pending = frame_q.size();

    // Track registers, predict on input transfers, compare output transfers
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            regs        <= '{RST_ATTACK, RST_RELEASE, RST_LINK, RST_DRIVE,
                             RST_BALANCE, RST_TRIM};
            chan_env[0] <= '0;
            chan_env[1] <= '0;
            link_env    <= '0;
            o_errors    <= 0;
            frame_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) frame_q = {frame_q, process_frame(i_s_tdata)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATTACK:  regs.att_coeff <= i_cfg_data[15:0];
                    CFG_RELEASE: regs.rel_coeff <= i_cfg_data[15:0];
                    CFG_LINK:    regs.link_amt  <= i_cfg_data;
                    CFG_DRIVE:   regs.drive     <= i_cfg_data[15:0];
                    CFG_BALANCE: regs.balance   <= i_cfg_data;
                    CFG_TRIM:    regs.trim      <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[76:0];
                if (frame_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected output frame %h", got);
                end else begin
                    want = frame_q.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("frame error: out0 %h/%h out1 %h/%h up %h/%h dn %h/%h",
                                     want.out0, got.out0, want.out1, got.out1,
                                     want.up_db, got.up_db, want.down_db, got.down_db);
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Up/down compressor band core testbench
// Drives stereo frames and register settings into the band core under random
// back-pressure on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ucb_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [16:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          src_idle = 38;
    int          dst_idle = 80;
    bit          stall_req = 0;
    int          stall_left = 0;
    int          level = 0;

    updown_compressor_band_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    updown_compressor_band_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_req) begin
            stall_left <= 3000;
            stall_req  <= 0;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= dst_idle);
        end
    end

    // Offer one frame, idling at random first; hold until transferred
    task automatic send_frame(input logic [23:0] ch0, input logic [23:0] ch1);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ch1, ch0};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drain, then write a full register set
    task automatic set_regs(input logic [16:0] att, input logic [16:0] rel,
                            input logic [16:0] lnk, input logic [16:0] drv,
                            input logic [16:0] bal, input logic [16:0] trm);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_ATTACK;  cfg_data <= att; @(posedge i_clk);
        cfg_idx <= CFG_RELEASE; cfg_data <= rel; @(posedge i_clk);
        cfg_idx <= CFG_LINK;    cfg_data <= lnk; @(posedge i_clk);
        cfg_idx <= CFG_DRIVE;   cfg_data <= drv; @(posedge i_clk);
        cfg_idx <= CFG_BALANCE; cfg_data <= bal; @(posedge i_clk);
        cfg_idx <= CFG_TRIM;    cfg_data <= trm; @(posedge i_clk);
        cfg_idx <= CFG_UNUSED;  cfg_data <= 17'h1FFFF; @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Bursts at a held level so the envelopes settle, with some raw noise
    function automatic logic [23:0] band_sample(input int lvl);
        logic [23:0] v;
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        v = 24'(($urandom & 24'h7F_FFFF) >> lvl);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes and loud/quiet swings at reset settings
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'hAAAAAA, 24'h555555);
        send_frame(24'h555555, 24'hAAAAAA);
        for (int i = 0; i < 6; i++) send_frame(24'h7FFFFF, 24'h000000);
        for (int i = 0; i < 6; i++) send_frame(24'h000010, 24'hFFFFF0);

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'h1F400);
                1: set_regs(17'd65535, 17'd65535, 17'd65536, 17'd45875, 17'd65536,
                            17'd3072);
                2: set_regs(17'd60000, 17'd65000, 17'h1FFFF, 17'd65535, 17'h1FFFF,
                            17'h00FFF);
                3: set_regs(17'd40000, 17'd65500, 17'd20000, 17'd30000, 17'd10000,
                            17'h01000);
                4: set_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                            17'($urandom), 17'($urandom));
                default: set_regs(17'd64685, 17'd65530, 17'd55706, 17'd15565,
                                  17'd32768, 17'd0);
            endcase
            if (ph < 2) begin
                src_idle = 38; dst_idle = 80;
            end else if (ph < 4) begin
                src_idle = 80; dst_idle = 38;
            end else begin
                src_idle = 0;  dst_idle = 0;
            end
            if (ph == 4) stall_req = 1;
            for (int i = 0; i < 150; i++) begin
                if (i % 16 == 0) level = $urandom_range(0, 23);
                send_frame(band_sample(level), band_sample(level));
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("updown_compressor_band_core: match");
        end else begin
            $display("updown_compressor_band_core: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("updown_compressor_band_core: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ucb_pkg.sv
hw/rtl/ucb_ctrl.sv
hw/rtl/ucb_dp.sv
hw/rtl/updown_compressor_band_core.sv
bench/updown_compressor_band_checker.sv
bench/tb.sv
